@@ hw/rtl/pnp_pkg.sv @@
// Shared types, character codes and digit decode for the prefixed radix parser.
// No dependencies; used by pnp_step and the top level.
package pnp_pkg;

  localparam int RESULT_BITS = 32;   // accumulator width, 8..64
  localparam int NUMBER_BITS = 32;   // width of the result port
  localparam int CHAR_BITS   = 8;

  localparam logic [CHAR_BITS-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_SP   = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_0    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_9    = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_A_UP = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_F_UP = 8'h46;
  localparam logic [CHAR_BITS-1:0] CH_A_LO = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_F_LO = 8'h66;
  localparam logic [CHAR_BITS-1:0] CH_B_UP = 8'h42;
  localparam logic [CHAR_BITS-1:0] CH_B_LO = 8'h62;
  localparam logic [CHAR_BITS-1:0] CH_O_UP = 8'h4F;
  localparam logic [CHAR_BITS-1:0] CH_O_LO = 8'h6F;
  localparam logic [CHAR_BITS-1:0] CH_X_UP = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_X_LO = 8'h78;
  localparam logic [3:0]           DIGIT_TEN = 4'd10;

  typedef enum logic [4:0] {
    PH_SKIP  = 5'b00001,
    PH_ZERO  = 5'b00010,
    PH_ACCUM = 5'b00100,
    PH_STOP  = 5'b01000,
    PH_ERROR = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_OCT = 2'd2,
    RX_BIN = 2'd3
  } radix_t;

  typedef struct packed {
    phase_t                 phase;
    radix_t                 radix;
    logic [RESULT_BITS-1:0] acc;
  } parse_state_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  localparam parse_state_t STATE_RESET = '{phase: PH_SKIP, radix: RX_DEC, acc: '0};

  // Digit value of c in radix rx; ok low when c is not a digit of that radix.
  function automatic digit_t digit_of(input logic [CHAR_BITS-1:0] c, input radix_t rx);
    digit_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r.val = 4'(c - CH_0);
      unique case (rx)
        RX_BIN:  r.ok = (r.val <= 4'd1);
        RX_OCT:  r.ok = (r.val <= 4'd7);
        default: r.ok = 1'b1;
      endcase
    end else if (rx == RX_HEX) begin
      if (c >= CH_A_LO && c <= CH_F_LO) begin
        r.ok  = 1'b1;
        r.val = 4'(c - CH_A_LO) + DIGIT_TEN;
      end else if (c >= CH_A_UP && c <= CH_F_UP) begin
        r.ok  = 1'b1;
        r.val = 4'(c - CH_A_UP) + DIGIT_TEN;
      end
    end
    return r;
  endfunction

  // value * base, by shifts plus one add for decimal; wraps at RESULT_BITS.
  function automatic logic [RESULT_BITS-1:0] times_base(input logic [RESULT_BITS-1:0] v,
                                                        input radix_t rx);
    logic [RESULT_BITS-1:0] r;
    unique case (rx)
      RX_HEX:  r = v << 4;
      RX_OCT:  r = v << 3;
      RX_BIN:  r = v << 1;
      default: r = (v << 3) + (v << 1);
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/pnp_step.sv @@
// Next-state and result logic for one character of the parser.
// Depends on pnp_pkg.
module pnp_step (
  input  pnp_pkg::parse_state_t             cur,
  input  logic [pnp_pkg::CHAR_BITS-1:0]     char_code,
  output pnp_pkg::parse_state_t             nxt,
  output logic                              term,
  output logic [pnp_pkg::NUMBER_BITS-1:0]   number,
  output logic                              status
);
  import pnp_pkg::*;

  digit_t                 dig;
  radix_t                 acc_rx;
  logic [RESULT_BITS-1:0] acc_sum;
  logic                   is_digit;
  logic                   err;
  logic [63:0]            acc_wide;

  // digit/accumulate path; radix is decimal in every phase but the accumulate phase
  always_comb begin
    acc_rx   = (cur.phase == PH_ACCUM) ? cur.radix : RX_DEC;
    dig      = digit_of(char_code, acc_rx);
    acc_sum  = times_base(cur.acc, acc_rx) + {{(RESULT_BITS-4){1'b0}}, dig.val};
    is_digit = (char_code >= CH_0) && (char_code <= CH_9);
  end

  always_comb begin
    term     = (char_code == CH_NUL);
    err      = (cur.phase == PH_SKIP) || (cur.phase == PH_ERROR);
    acc_wide = 64'(cur.acc);
    status   = err;
    number   = err ? '0 : acc_wide[NUMBER_BITS-1:0];
    nxt      = cur;
    if (term) begin
      nxt = STATE_RESET;
    end else begin
      unique case (cur.phase)
        PH_SKIP: begin
          if (char_code != CH_SP) begin
            nxt.radix = RX_DEC;
            nxt.acc   = '0;
            if (!is_digit) begin
              nxt.phase = PH_ERROR;
            end else if (char_code == CH_0) begin
              nxt.phase = PH_ZERO;
            end else begin
              nxt.phase = PH_ACCUM;
              nxt.acc   = acc_sum;   // acc is zero here, so this is the digit
            end
          end
        end
        PH_ZERO: begin
          if (char_code == CH_X_LO || char_code == CH_X_UP) begin
            nxt.radix = RX_HEX;
            nxt.phase = PH_ACCUM;
          end else if (char_code == CH_O_LO || char_code == CH_O_UP) begin
            nxt.radix = RX_OCT;
            nxt.phase = PH_ACCUM;
          end else if (char_code == CH_B_LO || char_code == CH_B_UP) begin
            nxt.radix = RX_BIN;
            nxt.phase = PH_ACCUM;
          end else begin
            nxt.radix = RX_DEC;
            if (dig.ok) begin
              nxt.phase = PH_ACCUM;
              nxt.acc   = acc_sum;
            end else begin
              nxt.phase = PH_STOP;
            end
          end
        end
        PH_ACCUM: begin
          if (dig.ok) begin
            nxt.acc = acc_sum;
          end else begin
            nxt.phase = PH_STOP;
          end
        end
        default: ;   // stopped, error and meaningless codes hold
      endcase
    end
  end

endmodule

@@ hw/rtl/prefixed_radix_number_parser.sv @@
// Prefixed radix number parser: one character per word, result at the NUL.
// Depends on pnp_pkg and pnp_step.
// A terminator accepted moves from the input register to the result register,
// which raises out_valid; it waits while the previous result is still stalled.
// Throughput: one character per cycle but for such waits (single-pass step logic).
// Reset: synchronous rst_n clears valids and state (skip spaces, decimal, zero).
module prefixed_radix_number_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pnp_pkg::CHAR_BITS-1:0]    in_char_code,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pnp_pkg::NUMBER_BITS-1:0]  out_number,
  output logic                             out_status
);
  import pnp_pkg::*;

  // Input register: one character word waiting for the step logic.
  logic                   s1_valid_r, s1_valid_nxt;
  logic [CHAR_BITS-1:0]   s1_char_r;

  // Parse state, updated once per character that passes through.
  parse_state_t           state_r, state_nxt;
  parse_state_t           step_nxt;

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  logic [NUMBER_BITS-1:0] out_number_r;
  logic                   out_status_r;

  logic                   step_term;
  logic [NUMBER_BITS-1:0] step_number;
  logic                   step_status;
  logic                   s1_fire;
  logic                   res_load;
  logic                   in_fire;

  pnp_step u_step (
    .cur       (state_r),
    .char_code (s1_char_r),
    .nxt       (step_nxt),
    .term      (step_term),
    .number    (step_number),
    .status    (step_status)
  );

  // A non-terminator always moves on; a terminator needs the result slot
  // empty or being drained this cycle.
  always_comb begin
    s1_fire  = s1_valid_r && (!step_term || !out_valid_r || out_ready);
    res_load = s1_fire && step_term;
    in_ready = !s1_valid_r || s1_fire;
    in_fire  = in_valid && in_ready;

    s1_valid_nxt = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    state_nxt    = s1_fire ? step_nxt : state_r;

    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_char_code;
    end
    if (res_load) begin
      out_number_r <= step_number;
      out_status_r <= step_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_number = out_number_r;
  assign out_status = out_status_r;

endmodule

@@ hw/rtl/pnp_checker.sv @@
// Port-level checker for prefixed_radix_number_parser, bound to the top level.
// Depends on pnp_pkg for widths.
module pnp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [pnp_pkg::NUMBER_BITS-1:0]  out_number,
  input logic                             out_status
);
  import pnp_pkg::*;

  // error results carry a zero number
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_number == '0))
    else $error("error result with nonzero number");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_number) && $stable(out_status)))
    else $error("stalled result changed");

  // no result straight out of reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with the result slot empty the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && $past(rst_n)) |-> in_ready)
    else $error("input stalled with empty result slot");

endmodule

bind prefixed_radix_number_parser pnp_checker u_pnp_checker (.*);

@@ sim/prefixed_radix_number_parser_test.sv @@
// Testbench for prefixed_radix_number_parser: directed strings, then random strings,
// each result checked against a behavioral parser, with random stalls on both sides.
// Depends on pnp_pkg and the parser RTL.
module prefixed_radix_number_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pnp_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RANDOM_ITEMS   = 800;
  localparam int CALM_ITEMS     = 100;     // tail of the run with no stalls at all
  localparam int DRAIN_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 100_000;

  // result status codes
  localparam logic ST_OK        = 1'b0;
  localparam logic ST_BAD_FIRST = 1'b1;    // first non-space char was not a digit, or none came

  typedef struct packed {
    logic [NUMBER_BITS-1:0] number;
    logic                   status;
  } parse_result_t;

  // directed string plus, where obvious, the result typed in by hand
  typedef struct {
    string                  text;
    bit                     typed;
    logic [NUMBER_BITS-1:0] number;
    logic                   status;
  } directed_row_t;

  typedef struct packed {
    logic          typed;
    parse_result_t result;
  } fixed_answer_t;

  logic                   clk;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_ready;
  logic [CHAR_BITS-1:0]   in_char_code = '0;
  logic                   out_valid;
  logic                   out_ready    = 1'b0;
  logic [NUMBER_BITS-1:0] out_number;
  logic                   out_status;

  prefixed_radix_number_parser dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_number   (out_number),
    .out_status   (out_status)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Directed strings; the NUL terminator is appended by the sender.
  // Octal escapes carry the bytes above 127.
  directed_row_t directed_rows [8] = '{
    '{"",            1'b1, 32'd0,   ST_BAD_FIRST},  // empty string
    '{" \377",       1'b1, 32'd0,   ST_BAD_FIRST},  // space, then byte 255
    '{"0",           1'b1, 32'd0,   ST_OK},         // lone zero
    '{"0x",          1'b1, 32'd0,   ST_OK},         // prefix, no digits
    '{"0XaF",        1'b1, 32'd175, ST_OK},         // hex, both letter cases
    '{"0B1\2002",    1'b1, 32'd1,   ST_OK},         // binary, byte 128 stops it
    '{"09",          1'b1, 32'd9,   ST_OK},         // leading zero, then decimal
    '{" 0o17x",      1'b0, 32'd0,   ST_OK}          // octal, stopped by a letter
  };

  parse_result_t awaited_results [$];   // predicted results, oldest first
  fixed_answer_t fixed_answers [$];     // one per directed string
  int            mismatches = 0;
  bit            calm       = 1'b0;     // no stalls on either side
  int            ready_hold = 0;

  // ---------------------------------------------------------------------------
  // Behavioral parser state
  // ---------------------------------------------------------------------------
  phase_t                 pr_phase = PH_SKIP;
  radix_t                 pr_radix = RX_DEC;
  logic [RESULT_BITS-1:0] pr_acc   = '0;

  function automatic int radix_base(input radix_t rx);
    case (rx)
      RX_HEX:  return 16;
      RX_OCT:  return 8;
      RX_BIN:  return 2;
      default: return 10;
    endcase
  endfunction

  // raw value of a char as a hex digit, 99 when it is none
  function automatic int digit_value(input logic [CHAR_BITS-1:0] c);
    if (c >= CH_0 && c <= CH_9)
      return int'(c) - int'(CH_0);
    if (c >= CH_A_LO && c <= CH_F_LO)
      return int'(c) - int'(CH_A_LO) + 10;
    if (c >= CH_A_UP && c <= CH_F_UP)
      return int'(c) - int'(CH_A_UP) + 10;
    return 99;
  endfunction

  function automatic void add_digit(input logic [CHAR_BITS-1:0] c);
    int          d;
    logic [63:0] wide;
    d = digit_value(c);
    if (d >= radix_base(pr_radix)) begin
      pr_phase = PH_STOP;
      return;
    end
    // 64-bit product, then wrap to the accumulator width
    wide     = 64'(pr_acc) * 64'(radix_base(pr_radix)) + 64'(d);
    pr_acc   = wide[RESULT_BITS-1:0];
    pr_phase = PH_ACCUM;
  endfunction

  // Advance the parser by one char; returns 1 with the result at the terminator.
  function automatic bit parse_char(input logic [CHAR_BITS-1:0] c,
                                    output parse_result_t res);
    logic [63:0] wide;
    res = '0;
    if (c == CH_NUL) begin
      if (pr_phase == PH_SKIP || pr_phase == PH_ERROR) begin
        res.number = '0;
        res.status = ST_BAD_FIRST;
      end else begin
        wide       = 64'(pr_acc);
        res.number = wide[NUMBER_BITS-1:0];
        res.status = ST_OK;
      end
      pr_phase = PH_SKIP;
      pr_radix = RX_DEC;
      pr_acc   = '0;
      return 1'b1;
    end
    case (pr_phase)
      PH_SKIP: begin
        if (c != CH_SP) begin
          pr_acc = '0;
          if (c < CH_0 || c > CH_9) begin
            pr_phase = PH_ERROR;
          end else begin
            pr_radix = RX_DEC;
            if (c == CH_0)
              pr_phase = PH_ZERO;
            else
              add_digit(c);
          end
        end
      end
      PH_ZERO: begin
        // prefix letter is consumed; anything else is a base-10 char
        if (c == CH_X_LO || c == CH_X_UP) begin
          pr_radix = RX_HEX;
          pr_phase = PH_ACCUM;
        end else if (c == CH_O_LO || c == CH_O_UP) begin
          pr_radix = RX_OCT;
          pr_phase = PH_ACCUM;
        end else if (c == CH_B_LO || c == CH_B_UP) begin
          pr_radix = RX_BIN;
          pr_phase = PH_ACCUM;
        end else begin
          pr_radix = RX_DEC;
          add_digit(c);
        end
      end
      PH_ACCUM: add_digit(c);
      default: ;  // stopped or error: ignore until the terminator
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input word, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    parse_result_t want;
    parse_result_t got;
    fixed_answer_t row;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (parse_char(in_char_code, want)) begin
          // directed strings may carry a hand-written answer instead
          if (fixed_answers.size() != 0) begin
            row = fixed_answers.pop_front();
            if (row.typed)
              want = row.result;
          end
          awaited_results.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        got.number = out_number;
        got.status = out_status;
        if (awaited_results.size() == 0) begin
          $error("unexpected result: number %0d status %0d", out_number, out_status);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (got.number !== want.number) begin
            $error("number: expected %0d, got %0d", want.number, got.number);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
        end
      end
    end
  end

  // Result side back-pressure: random stall bursts, none in the calm tail.
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [CHAR_BITS-1:0] c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_string(input logic [CHAR_BITS-1:0] chars [$]);
    foreach (chars[i])
      send_char(chars[i]);
    send_char(CH_NUL);
  endtask

  // Hold off input until every predicted result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  function automatic logic [CHAR_BITS-1:0] random_digit(input radix_t rx);
    int v;
    v = $urandom_range(0, radix_base(rx) - 1);
    if (v < 10)
      return CH_0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + 8'(v - 10);
  endfunction

  // Mostly well-formed numbers with random digits; some noise and junk tails.
  // useful counts the words that the parser actually acts on.
  function automatic void make_string(output logic [CHAR_BITS-1:0] s [$], output int useful);
    radix_t rx;
    int     n;
    s  = {};
    rx = RX_DEC;
    repeat ($urandom_range(0, 2)) s.push_back(CH_SP);
    if ($urandom_range(0, 9) < 2) begin
      // noise: random bytes, often a bad first char; may be all spaces
      repeat ($urandom_range(0, 6)) s.push_back(8'($urandom_range(1, 255)));
      useful = s.size() + 1;
      return;
    end
    if ($urandom_range(0, 2) == 0) begin
      s.push_back(CH_0 + 8'($urandom_range(1, 9)));
    end else begin
      s.push_back(CH_0);
      case ($urandom_range(0, 3))
        0: begin
          rx = RX_HEX;
          s.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
        end
        1: begin
          rx = RX_OCT;
          s.push_back($urandom_range(0, 1) ? CH_O_UP : CH_O_LO);
        end
        2: begin
          rx = RX_BIN;
          s.push_back($urandom_range(0, 1) ? CH_B_UP : CH_B_LO);
        end
        default: rx = RX_DEC;   // leading zero, decimal digits follow
      endcase
    end
    // long runs can make the accumulator wrap
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 8);
    repeat (n) s.push_back(random_digit(rx));
    useful = s.size() + 1;
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 4)) s.push_back(8'($urandom_range(1, 255)));
  endfunction

  initial begin
    logic [CHAR_BITS-1:0] chars [$];
    int                   useful;
    int                   random_chars;
    fixed_answer_t        answer;
    random_chars = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[r]) begin
      answer.typed         = directed_rows[r].typed;
      answer.result.number = directed_rows[r].number;
      answer.result.status = directed_rows[r].status;
      fixed_answers.push_back(answer);
      chars = {};
      for (int i = 0; i < directed_rows[r].text.len(); i++)
        chars.push_back(directed_rows[r].text[i]);
      send_string(chars);
    end

    // let the result side run dry before the random part
    wait_for_results();

    while (random_chars < RANDOM_ITEMS) begin
      make_string(chars, useful);
      send_string(chars);
      random_chars += useful;
      calm = (random_chars >= RANDOM_ITEMS - CALM_ITEMS);
      if (!calm && $urandom_range(0, 49) == 0)
        wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // hard stop if the parser hangs
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

endmodule
